// ----- hdl/pwe_pkg.sv -----
package pwe_pkg;

    localparam int CoordWidth  = 32;
    localparam int NormWidth   = 16;
    localparam int IndexWidth  = 16;
    localparam int QueueDepth  = 2;
    localparam int QuadResults = 10;

    localparam logic [0:0] CfgFloorHeight = 1'b0;
    localparam logic [0:0] CfgBaseVertex  = 1'b1;

    localparam logic KindVertex = 1'b0;
    localparam logic KindIndex  = 1'b1;

    localparam logic [14:0] OneQ14 = 15'd16384;

    typedef struct packed {
        logic [CoordWidth-1:0] px;
        logic [CoordWidth-1:0] py;
        logic [CoordWidth-1:0] pz;
        logic [CoordWidth-1:0] cx;
        logic [CoordWidth-1:0] cy;
        logic signed [CoordWidth:0] dx;
        logic signed [CoordWidth:0] dy;
    } edge_t;

    // Offsets of the six triangle indices of one wall quad.
    function automatic logic [1:0] index_offset(input logic [2:0] slot);
        logic [1:0] off;
        unique case (slot)
            3'd0:    off = 2'd0;
            3'd1:    off = 2'd2;
            3'd2:    off = 2'd1;
            3'd3:    off = 2'd1;
            3'd4:    off = 2'd2;
            3'd5:    off = 2'd3;
            default: off = 2'd0;
        endcase
        return off;
    endfunction

endpackage

// ----- hdl/pwe_front.sv -----
module pwe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pwe_pkg::CoordWidth-1:0]    point_x,
    input  logic [pwe_pkg::CoordWidth-1:0]    point_y,
    input  logic [pwe_pkg::CoordWidth-1:0]    point_z,
    input  logic                              ring_start,
    input  logic                              queue_full,
    output logic                              push,
    output pwe_pkg::edge_t                    push_edge
);

    logic [pwe_pkg::CoordWidth-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic have_prev_reg;
    logic accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && have_prev_reg && !ring_start;

    always_comb
    begin
        push_edge.px = prev_x_reg;
        push_edge.py = prev_y_reg;
        push_edge.pz = prev_z_reg;
        push_edge.cx = point_x;
        push_edge.cy = point_y;
        push_edge.dx = $signed({point_x[31], point_x}) - $signed({prev_x_reg[31], prev_x_reg});
        push_edge.dy = $signed({point_y[31], point_y}) - $signed({prev_y_reg[31], prev_y_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_x_reg    <= point_x;
            prev_y_reg    <= point_y;
            prev_z_reg    <= point_z;
            have_prev_reg <= 1'b1;
        end
    end

endmodule

// ----- hdl/pwe_queue.sv -----
module pwe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwe_pkg::edge_t push_edge,
    input  logic           pop,
    output pwe_pkg::edge_t head,
    output logic           empty,
    output logic           full
);

    localparam int PtrW = $clog2(pwe_pkg::QueueDepth);

    pwe_pkg::edge_t   slots_reg [pwe_pkg::QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]    count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PtrW+1)'(pwe_pkg::QueueDepth));
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_edge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/pwe_back.sv -----
module pwe_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pwe_pkg::edge_t                     head,
    input  logic                               empty,
    output logic                               pop,
    input  logic [pwe_pkg::CoordWidth-1:0]     floor_height,
    input  logic                               base_load,
    input  logic [pwe_pkg::IndexWidth-1:0]     base_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               item_kind,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_x,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_y,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_z,
    output logic [pwe_pkg::NormWidth-1:0]      normal_x,
    output logic [pwe_pkg::NormWidth-1:0]      normal_y,
    output logic [pwe_pkg::IndexWidth-1:0]     vertex_index,
    output logic                               last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DSET = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [32:0] a_reg, a_next, b_reg, b_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;
    logic [61:0] aa_reg, aa_next, bb_reg, bb_next;
    logic [63:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rema_reg, rema_next, remb_reg, remb_next;
    logic [14:0] lowa_reg, lowa_next, lowb_reg, lowb_next;
    logic [14:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [15:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [3:0]  k_reg, k_next;
    logic [15:0] nv_reg, nv_next;

    logic        ov_reg, ov_next;
    logic        kind_reg, kind_next, last_reg, last_next;
    logic [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [15:0] onx_reg, onx_next, ony_reg, ony_next, oidx_reg, oidx_next;

    logic [32:0] mx, abs_dx, abs_dy, tmpa, tmpb;
    logic [63:0] trial;
    logic [45:0] numa, numb;
    logic        slot_free;
    logic [14:0] qa_c, qb_c;

    assign slot_free = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg;  b_next = b_reg;
        negx_next = negx_reg;  negy_next = negy_reg;
        aa_next = aa_reg;  bb_next = bb_reg;
        v_next = v_reg;  res_next = res_reg;  bit_next = bit_reg;
        cnt_next = cnt_reg;  len_next = len_reg;
        rema_next = rema_reg;  remb_next = remb_reg;
        lowa_next = lowa_reg;  lowb_next = lowb_reg;
        qa_next = qa_reg;  qb_next = qb_reg;
        nx_next = nx_reg;  ny_next = ny_reg;
        k_next = k_reg;  nv_next = nv_reg;
        ov_next = ov_reg && out_stall;
        kind_next = kind_reg;  last_next = last_reg;
        ox_next = ox_reg;  oy_next = oy_reg;  oz_next = oz_reg;
        onx_next = onx_reg;  ony_next = ony_reg;  oidx_next = oidx_reg;
        pop = 1'b0;

        abs_dx = head.dx[32] ? 33'(-head.dx) : 33'(head.dx);
        abs_dy = head.dy[32] ? 33'(-head.dy) : 33'(head.dy);
        mx     = (a_reg > b_reg) ? a_reg : b_reg;
        trial  = res_reg + bit_reg;
        // The square root result is the length here; its half rounds the quotient.
        numa   = {a_reg[30:0], 14'd0} + 46'(res_reg[31:1]);
        numb   = {b_reg[30:0], 14'd0} + 46'(res_reg[31:1]);
        tmpa   = {rema_reg, lowa_reg[14]};
        tmpb   = {remb_reg, lowb_reg[14]};
        qa_c   = (qa_reg > OneQ14c()) ? OneQ14c() : qa_reg;
        qb_c   = (qb_reg > OneQ14c()) ? OneQ14c() : qb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    a_next    = abs_dy;
                    b_next    = abs_dx;
                    negx_next = !head.dy[32] && (head.dy != '0);
                    negy_next = head.dx[32];
                    k_next    = '0;
                    if (head.dx == '0 && head.dy == '0)
                    begin
                        nx_next    = '0;
                        ny_next    = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                // One bit of shift a cycle until the larger magnitude sits in [2^30, 2^31).
                if (mx[32:30] == 3'd0)
                begin
                    a_next = {a_reg[31:0], 1'b0};
                    b_next = {b_reg[31:0], 1'b0};
                end
                else if (mx[32:31] != 2'd0)
                begin
                    a_next = {1'b0, a_reg[32:1]};
                    b_next = {1'b0, b_reg[32:1]};
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                aa_next    = a_reg[30:0] * a_reg[30:0];
                bb_next    = b_reg[30:0] * b_reg[30:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                v_next     = 64'(aa_reg) + 64'(bb_reg);
                res_next   = '0;
                bit_next   = 64'd1 << 62;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_DSET;
                end
            end
            S_DSET:
            begin
                len_next   = res_reg[31:0];
                rema_next  = 32'(numa[45:15]);
                remb_next  = 32'(numb[45:15]);
                lowa_next  = numa[14:0];
                lowb_next  = numb[14:0];
                qa_next    = '0;
                qb_next    = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // The upper numerator bits start below the length, so fifteen steps suffice.
                if (cnt_reg[4])
                begin
                    nx_next    = negx_reg ? 16'(-{1'b0, qa_c}) : {1'b0, qa_c};
                    ny_next    = negy_reg ? 16'(-{1'b0, qb_c}) : {1'b0, qb_c};
                    state_next = S_EMIT;
                end
                else
                begin
                    if (tmpa >= {1'b0, len_reg})
                    begin
                        rema_next = 32'(tmpa - {1'b0, len_reg});
                        qa_next   = {qa_reg[13:0], 1'b1};
                    end
                    else
                    begin
                        rema_next = tmpa[31:0];
                        qa_next   = {qa_reg[13:0], 1'b0};
                    end
                    if (tmpb >= {1'b0, len_reg})
                    begin
                        remb_next = 32'(tmpb - {1'b0, len_reg});
                        qb_next   = {qb_reg[13:0], 1'b1};
                    end
                    else
                    begin
                        remb_next = tmpb[31:0];
                        qb_next   = {qb_reg[13:0], 1'b0};
                    end
                    lowa_next = {lowa_reg[13:0], 1'b0};
                    lowb_next = {lowb_reg[13:0], 1'b0};
                    cnt_next  = (cnt_reg == 5'd14) ? 5'd16 : cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    last_next = (k_reg == 4'(QuadResultsLast()));
                    if (k_reg < 4'd4)
                    begin
                        kind_next = pwe_pkg::KindVertex;
                        ox_next   = k_reg[0] ? head.cx : head.px;
                        oy_next   = k_reg[0] ? head.cy : head.py;
                        oz_next   = k_reg[1] ? floor_height : head.pz;
                        onx_next  = nx_reg;
                        ony_next  = ny_reg;
                        oidx_next = '0;
                    end
                    else
                    begin
                        kind_next = pwe_pkg::KindIndex;
                        ox_next   = '0;
                        oy_next   = '0;
                        oz_next   = '0;
                        onx_next  = '0;
                        ony_next  = '0;
                        oidx_next = nv_reg + 16'(pwe_pkg::index_offset(3'(k_reg - 4'd4)));
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == 4'(QuadResultsLast()))
                    begin
                        pop        = 1'b1;
                        nv_next    = nv_reg + 16'd4;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (base_load)
        begin
            nv_next = base_value;
        end
    end

    function automatic logic [14:0] OneQ14c();
        return pwe_pkg::OneQ14;
    endfunction

    function automatic int QuadResultsLast();
        return pwe_pkg::QuadResults - 1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            nv_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            nv_reg    <= nv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;  b_reg <= b_next;
        negx_reg <= negx_next;  negy_reg <= negy_next;
        aa_reg <= aa_next;  bb_reg <= bb_next;
        v_reg <= v_next;  res_reg <= res_next;  bit_reg <= bit_next;
        len_reg <= len_next;
        rema_reg <= rema_next;  remb_reg <= remb_next;
        lowa_reg <= lowa_next;  lowb_reg <= lowb_next;
        qa_reg <= qa_next;  qb_reg <= qb_next;
        nx_reg <= nx_next;  ny_reg <= ny_next;
        kind_reg <= kind_next;  last_reg <= last_next;
        ox_reg <= ox_next;  oy_reg <= oy_next;  oz_reg <= oz_next;
        onx_reg <= onx_next;  ony_reg <= ony_next;  oidx_reg <= oidx_next;
    end

    assign out_valid    = ov_reg;
    assign item_kind    = kind_reg;
    assign vertex_x     = ox_reg;
    assign vertex_y     = oy_reg;
    assign vertex_z     = oz_reg;
    assign normal_x     = onx_reg;
    assign normal_y     = ony_reg;
    assign vertex_index = oidx_reg;
    assign last         = last_reg;

    a_emit_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !empty)
        else $error("emitting a quad with no edge queued");

    a_vertex_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && kind_reg == pwe_pkg::KindVertex) |-> (oidx_reg == '0))
        else $error("vertex result carries an index");

    a_index_no_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && kind_reg == pwe_pkg::KindIndex) |-> (onx_reg == '0 && ony_reg == '0))
        else $error("index result carries a normal");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (ov_reg && last_reg && kind_reg == pwe_pkg::KindIndex))
        else $error("edge retired without its final index");

endmodule

// ----- hdl/polygon_wall_extruder_top.sv -----
// Polygon wall extruder.
// Input channel (in_valid/in_stall): one outline point per item, with
// ring_start marking the first point of a ring. Output channel
// (out_valid/out_stall): ten results per edge, four wall vertices with the
// Q1.14 normal and then six triangle indices; last marks the tenth.
// A ring-start point produces no results. The front stores the previous
// point and queues edges in a two-entry queue; the back normalizes the
// edge (one shift per cycle, a registered square, a 32-step square root
// and two 15-step dividers) and then emits one result per cycle while
// out_stall is low. A zero-length edge skips normalizing and goes
// straight to emission. The queue holds the edge in progress until its
// last result, so the front can queue one more edge while an edge is
// in progress. A stalled receiver holds the current result and pauses
// emission; in_stall rises only when the queue is full.
// Reset clears the stored point, the queue and the output valid flag,
// and sets both registers and the index counter to zero. Write cfg_index 1
// to load the index counter; write only while the block is idle.
module polygon_wall_extruder_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pwe_pkg::CoordWidth-1:0]     point_x,
    input  logic [pwe_pkg::CoordWidth-1:0]     point_y,
    input  logic [pwe_pkg::CoordWidth-1:0]     point_z,
    input  logic                               ring_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               item_kind,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_x,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_y,
    output logic [pwe_pkg::CoordWidth-1:0]     vertex_z,
    output logic [pwe_pkg::NormWidth-1:0]      normal_x,
    output logic [pwe_pkg::NormWidth-1:0]      normal_y,
    output logic [pwe_pkg::IndexWidth-1:0]     vertex_index,
    output logic                               last
);

    logic [31:0]    floor_height_reg;
    logic           push, pop, empty, full, base_load;
    pwe_pkg::edge_t push_edge, head;

    assign base_load = cfg_we && (cfg_index == pwe_pkg::CfgBaseVertex);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_height_reg <= '0;
        end
        else if (cfg_we && cfg_index == pwe_pkg::CfgFloorHeight)
        begin
            floor_height_reg <= cfg_data;
        end
    end

    pwe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .ring_start (ring_start),
        .queue_full (full),
        .push       (push),
        .push_edge  (push_edge)
    );

    pwe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_edge (push_edge),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    pwe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .floor_height (floor_height_reg),
        .base_load    (base_load),
        .base_value   (cfg_data[15:0]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .vertex_index (vertex_index),
        .last         (last)
    );

endmodule

// ----- verif/wall_checker.sv -----
`timescale 1ns / 1ps

module wall_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [pwe_pkg::CoordWidth-1:0] point_x,
    input  logic [pwe_pkg::CoordWidth-1:0] point_y,
    input  logic [pwe_pkg::CoordWidth-1:0] point_z,
    input  logic                           ring_start,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           item_kind,
    input  logic [pwe_pkg::CoordWidth-1:0] vertex_x,
    input  logic [pwe_pkg::CoordWidth-1:0] vertex_y,
    input  logic [pwe_pkg::CoordWidth-1:0] vertex_z,
    input  logic [pwe_pkg::NormWidth-1:0]  normal_x,
    input  logic [pwe_pkg::NormWidth-1:0]  normal_y,
    input  logic [pwe_pkg::IndexWidth-1:0] vertex_index,
    input  logic                           last,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             edges_seen
);

    typedef struct packed {
        logic                           kind;
        logic [pwe_pkg::CoordWidth-1:0] x;
        logic [pwe_pkg::CoordWidth-1:0] y;
        logic [pwe_pkg::CoordWidth-1:0] z;
        logic [pwe_pkg::NormWidth-1:0]  nx;
        logic [pwe_pkg::NormWidth-1:0]  ny;
        logic [pwe_pkg::IndexWidth-1:0] idx;
        logic                           fin;
    } wall_result_t;

    wall_result_t expected_walls[$];
    logic [31:0] floor_z;
    logic [15:0] vertex_counter;
    logic [31:0] last_x, last_y, last_z;
    logic        have_point;

    task automatic add_wall(input wall_result_t r);
        expected_walls = {expected_walls, r};
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Normal is (-dy, dx) scaled to unit length in Q1.14.
    task automatic unit_normal(input logic signed [32:0] dx, input logic signed [32:0] dy,
                               output logic [15:0] nx, output logic [15:0] ny);
        logic [63:0] a, b, m, len, qa, qb;
        a = (dy < 0) ? 64'(-dy) : 64'(dy);
        b = (dx < 0) ? 64'(-dx) : 64'(dx);
        nx = 0;
        ny = 0;
        if (a == 0 && b == 0) return;
        m = (a > b) ? a : b;
        while (m < (64'd1 << 30)) begin a = a << 1; b = b << 1; m = m << 1; end
        while (m >= (64'd1 << 31)) begin a = a >> 1; b = b >> 1; m = m >> 1; end
        len = int_sqrt(a * a + b * b);
        if (len == 0) return;
        qa = (a * 16384 + len / 2) / len;
        qb = (b * 16384 + len / 2) / len;
        if (qa > 16384) qa = 16384;
        if (qb > 16384) qb = 16384;
        nx = (dy > 0) ? 16'(-qa) : 16'(qa);
        ny = (dx < 0) ? 16'(-qb) : 16'(qb);
    endtask

    task automatic extrude_point(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] cz, input logic start);
        logic [15:0] nx, ny;
        logic [1:0] offs[6];
        offs = '{2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3};
        if (start || !have_point)
        begin
            last_x = cx;
            last_y = cy;
            last_z = cz;
            have_point = 1'b1;
            return;
        end
        unit_normal($signed({cx[31], cx}) - $signed({last_x[31], last_x}),
                    $signed({cy[31], cy}) - $signed({last_y[31], last_y}), nx, ny);
        add_wall({pwe_pkg::KindVertex, last_x, last_y, last_z, nx, ny, 16'd0, 1'b0});
        add_wall({pwe_pkg::KindVertex, cx, cy, last_z, nx, ny, 16'd0, 1'b0});
        add_wall({pwe_pkg::KindVertex, last_x, last_y, floor_z, nx, ny, 16'd0, 1'b0});
        add_wall({pwe_pkg::KindVertex, cx, cy, floor_z, nx, ny, 16'd0, 1'b0});
        for (int i = 0; i < 6; i++)
            add_wall({pwe_pkg::KindIndex, 96'd0, 32'd0,
                      16'(vertex_counter + offs[i]), i == 5});
        vertex_counter = vertex_counter + 16'd4;
        last_x = cx;
        last_y = cy;
        last_z = cz;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wall_result_t got, want;
        if (!rst_n)
        begin
            expected_walls.delete();
            floor_z = 0;
            vertex_counter = 0;
            last_x = 0;
            last_y = 0;
            last_z = 0;
            have_point = 0;
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            edges_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pwe_pkg::CfgFloorHeight)
                    floor_z = cfg_data;
                else
                begin
                    vertex_counter = cfg_data[15:0];
                end
            end
            if (in_valid && !in_stall)
                extrude_point(point_x, point_y, point_z, ring_start);
            if (out_valid && !out_stall)
            begin
                got = {item_kind, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                       vertex_index, last};
                results_seen++;
                if (last) edges_seen++;
                if (expected_walls.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_walls.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch expected: kind %b xyz %h %h %h n %h %h idx %h last %b",
                                     want.kind, want.x, want.y, want.z, want.nx, want.ny,
                                     want.idx, want.fin);
                            $display("         actual:   kind %b xyz %h %h %h n %h %h idx %h last %b",
                                     got.kind, got.x, got.y, got.z, got.nx, got.ny,
                                     got.idx, got.fin);
                        end
                    end
                end
            end
            pending = expected_walls.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid, in_stall;
    logic [31:0] point_x, point_y, point_z;
    logic ring_start;
    logic out_valid, out_stall;
    logic item_kind, last;
    logic [31:0] vertex_x, vertex_y, vertex_z;
    logic [15:0] normal_x, normal_y, vertex_index;
    int fail_count, pending, results_seen, edges_seen;
    int send_idle_pct;
    int recv_idle_pct;

    polygon_wall_extruder_top dut (.*);

    wall_checker checker_i (.*);

    always
    begin
        clk = 0;
        #10;
        clk = 1;
        #10;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Holds the point until the block takes it, idling first at random.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        ring_start <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(65536 * 200)) - 65536 * 100);
        endcase
    endfunction

    task automatic random_rings(input int count);
        logic [31:0] x, y;
        int left;
        left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && $urandom_range(19) == 0)
            begin
                // Occasional repeated point, a zero-length edge.
                send_point(x, y, $urandom, 0);
                continue;
            end
            x = rand_coord();
            y = rand_coord();
            send_point(x, y, rand_coord(), left == 0);
            left = (left == 0) ? $urandom_range(8, 2) : left - 1;
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = pwe_pkg::CfgFloorHeight;
        cfg_data = 0;
        in_valid = 0;
        point_x = 0;
        point_y = 0;
        point_z = 0;
        ring_start = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // First point after reset without a ring start opens a ring anyway.
        send_point(0, 0, 32'h0001_0000, 0);
        send_point(32'h0001_0000, 0, 32'h0002_0000, 0);
        send_point(32'h0001_0000, 0, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0001, 1, 0);
        send_point(5, 3, 0, 1);
        send_point(4, 3, 0, 0);
        send_point(4, 2, 0, 0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        drain();
        write_reg(pwe_pkg::CfgFloorHeight, 32'h8000_0000);
        write_reg(pwe_pkg::CfgBaseVertex, 32'hFFFF_FFFE);
        send_point(1, 2, 3, 1);
        send_point(32'h0003_0000, 32'hFFFC_0000, 7, 0);
        send_point(32'h0003_0000, 32'hFFFC_0000, 7, 0);
        drain();
        write_reg(pwe_pkg::CfgFloorHeight, 32'h7FFF_FFFF);
        write_reg(pwe_pkg::CfgBaseVertex, 32'h0000_FFF0);

        send_idle_pct = 32;
        recv_idle_pct = 46;
        random_rings(78);
        drain();
        write_reg(pwe_pkg::CfgFloorHeight, $urandom);
        write_reg(pwe_pkg::CfgBaseVertex, $urandom);
        send_idle_pct = 46;
        recv_idle_pct = 32;
        random_rings(78);
        drain();
        write_reg(pwe_pkg::CfgFloorHeight, 32'hFFFF_0000);
        write_reg(pwe_pkg::CfgBaseVertex, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_rings(78);
        drain();

        $display("Sent 249 outline points under five register settings and three stall mixes;");
        $display("%0d wall edges and %0d results were compared.", edges_seen, results_seen);
        if (fail_count == 0)
            $display("polygon_wall_extruder_top verification clean");
        else
            $display("polygon_wall_extruder_top verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("polygon_wall_extruder_top verification failed");
        $finish;
    end

endmodule
